// ----- design/xml_entity_to_utf8_decoder_defines.svh -----
// Assertion macros for the XML entity to UTF-8 decoder
`ifndef XML_ENTITY_TO_UTF8_DECODER_DEFINES_SVH
`define XML_ENTITY_TO_UTF8_DECODER_DEFINES_SVH

// same-cycle implication
`define XED_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define XED_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/xed_pkg.sv -----
// Types, constants and lookup functions shared by the entity decoder
package xed_pkg;

  localparam int unsigned ACC_W = 22;
  localparam int unsigned MUL_W = 26;

  localparam logic [ACC_W-1:0] CP_LIMIT = 22'h1FFFFF;
  localparam logic [ACC_W-1:0] CP_SAT   = 22'h200000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ESC = 2'd1;
  localparam logic [1:0] ST_BAD_CP  = 2'd2;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_X    = 8'h78;

  localparam int unsigned N_ENT = 5;

  // up to four result bytes produced by one item
  typedef struct packed {
    logic            valid;
    logic [1:0]      top;
    logic [3:0][7:0] bytes;
    logic [1:0]      status;
    logic            last;
  } pack_t;

  function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      3'd0: case (i) 3'd0: c = "l"; 3'd1: c = "t"; 3'd2: c = ";"; default: c = 8'h00; endcase
      3'd1: case (i) 3'd0: c = "g"; 3'd1: c = "t"; 3'd2: c = ";"; default: c = 8'h00; endcase
      3'd2: case (i)
              3'd0: c = "a"; 3'd1: c = "m"; 3'd2: c = "p"; 3'd3: c = ";";
              default: c = 8'h00;
            endcase
      3'd3: case (i)
              3'd0: c = "a"; 3'd1: c = "p"; 3'd2: c = "o"; 3'd3: c = "s"; 3'd4: c = ";";
              default: c = 8'h00;
            endcase
      3'd4: case (i)
              3'd0: c = "q"; 3'd1: c = "u"; 3'd2: c = "o"; 3'd3: c = "t"; 3'd4: c = ";";
              default: c = 8'h00;
            endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0, 3'd1: n = 3'd3;
      3'd2:       n = 3'd4;
      default:    n = 3'd5;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ent_out(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = "<";
      3'd1:    c = ">";
      3'd2:    c = "&";
      3'd3:    c = 8'h27;
      default: c = 8'h22;
    endcase
    return c;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, b[3:0]};
    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      r = {1'b1, b[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

// ----- design/xed_parser.sv -----
// Entity parser: state registers and single-pass decode of one item
module xed_parser import xed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output pack_t      pack_o
);

  localparam logic [2:0] MODE_PLAIN = 3'd0;
  localparam logic [2:0] MODE_AMP   = 3'd1;
  localparam logic [2:0] MODE_NAMED = 3'd2;
  localparam logic [2:0] MODE_HASH  = 3'd3;
  localparam logic [2:0] MODE_DEC   = 3'd4;
  localparam logic [2:0] MODE_HEXX  = 3'd5;
  localparam logic [2:0] MODE_HEX   = 3'd6;

  logic [2:0]       mode_q, mode_d;
  logic [4:0]       mask_q, mask_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             drop_q, drop_d;

  logic [MUL_W-1:0] dec_sum, hex_sum;
  logic [ACC_W-1:0] dec_acc, hex_acc;
  logic [4:0]       hexd;
  logic             is_dec;

  assign hexd    = hex_val(byte_i);
  assign is_dec  = (byte_i >= "0") && (byte_i <= "9");
  assign dec_sum = ({{(MUL_W-ACC_W){1'b0}}, acc_q} << 3)
                 + ({{(MUL_W-ACC_W){1'b0}}, acc_q} << 1)
                 + {{(MUL_W-4){1'b0}}, byte_i[3:0]};
  assign hex_sum = {acc_q, hexd[3:0]};
  assign dec_acc = (dec_sum > {{(MUL_W-ACC_W){1'b0}}, CP_LIMIT}) ? CP_SAT
                                                                : dec_sum[ACC_W-1:0];
  assign hex_acc = (hex_sum > {{(MUL_W-ACC_W){1'b0}}, CP_LIMIT}) ? CP_SAT
                                                                : hex_sum[ACC_W-1:0];

  always_comb begin
    logic       done;
    logic       fail;
    logic       emit;
    logic [1:0] fst;
    logic [4:0] mask_e;
    logic [2:0] idx;
    logic [4:0] keep;
    logic       hit;
    logic [7:0] hit_ch;
    logic [20:0] cp;

    mode_d = mode_q;
    mask_d = mask_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    drop_d = drop_q;
    pack_o = '0;
    done   = 1'b0;
    fail   = 1'b0;
    emit   = 1'b0;
    fst    = ST_BAD_ESC;
    mask_e = 5'h1F;
    idx    = 3'd0;
    keep   = 5'd0;
    hit    = 1'b0;
    hit_ch = 8'h00;
    cp     = acc_q[20:0];

    if (drop_q) begin
      done = 1'b1;
      if (last_i) begin
        drop_d = 1'b0;
        mode_d = MODE_PLAIN;
        mask_d = '0;
        cnt_d  = '0;
        acc_d  = '0;
      end
    end else begin
      unique case (mode_q) inside
        MODE_PLAIN: begin
          if (byte_i != CH_AMP) begin
            pack_o.valid    = 1'b1;
            pack_o.bytes[0] = byte_i;
            pack_o.last     = last_i;
            done            = 1'b1;
          end else begin
            mode_d = MODE_AMP;
          end
        end
        MODE_AMP, MODE_NAMED: begin
          if (mode_q == MODE_AMP && byte_i == CH_HASH) begin
            mode_d = MODE_HASH;
          end else begin
            if (mode_q == MODE_NAMED) begin
              mask_e = mask_q;
              idx    = cnt_q;
            end
            for (int k = 0; k < N_ENT; k++) begin
              keep[k] = mask_e[k] && (idx < ent_len(3'(k)))
                        && (ent_char(3'(k), idx) == byte_i);
            end
            for (int k = 0; k < N_ENT; k++) begin
              if (keep[k] && ent_len(3'(k)) == idx + 3'd1) begin
                hit    = 1'b1;
                hit_ch = ent_out(3'(k));
              end
            end
            if (keep == 5'd0) begin
              fail = 1'b1;
            end else if (hit) begin
              pack_o.valid    = 1'b1;
              pack_o.bytes[0] = hit_ch;
              pack_o.last     = last_i;
              mode_d          = MODE_PLAIN;
              mask_d          = '0;
              cnt_d           = '0;
              acc_d           = '0;
              done            = 1'b1;
            end else begin
              mode_d = MODE_NAMED;
              mask_d = keep;
              cnt_d  = idx + 3'd1;
            end
          end
        end
        MODE_HASH: begin
          if (is_dec) begin
            acc_d  = {{(ACC_W-4){1'b0}}, byte_i[3:0]};
            mode_d = MODE_DEC;
          end else if (byte_i == CH_X) begin
            acc_d  = '0;
            mode_d = MODE_HEXX;
          end else begin
            fail = 1'b1;
          end
        end
        MODE_DEC: begin
          if (is_dec) begin
            acc_d = dec_acc;
          end else if (byte_i == CH_SEMI) begin
            emit = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        MODE_HEXX, MODE_HEX: begin
          if (hexd[4]) begin
            acc_d  = hex_acc;
            mode_d = MODE_HEX;
          end else if (byte_i == CH_SEMI && mode_q == MODE_HEX) begin
            emit = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase

      if (emit) begin
        done = 1'b1;
        if (acc_q > CP_LIMIT) begin
          fail = 1'b1;
          fst  = ST_BAD_CP;
        end else begin
          pack_o.valid = 1'b1;
          pack_o.last  = last_i;
          if (acc_q <= 22'h7F) begin
            pack_o.top      = 2'd0;
            pack_o.bytes[0] = {1'b0, cp[6:0]};
          end else if (acc_q <= 22'h7FF) begin
            pack_o.top      = 2'd1;
            pack_o.bytes[0] = {3'b110, cp[10:6]};
            pack_o.bytes[1] = {2'b10, cp[5:0]};
          end else if (acc_q <= 22'hFFFF) begin
            pack_o.top      = 2'd2;
            pack_o.bytes[0] = {4'b1110, cp[15:12]};
            pack_o.bytes[1] = {2'b10, cp[11:6]};
            pack_o.bytes[2] = {2'b10, cp[5:0]};
          end else begin
            pack_o.top      = 2'd3;
            pack_o.bytes[0] = {5'b11110, cp[20:18]};
            pack_o.bytes[1] = {2'b10, cp[17:12]};
            pack_o.bytes[2] = {2'b10, cp[11:6]};
            pack_o.bytes[3] = {2'b10, cp[5:0]};
          end
          mode_d = MODE_PLAIN;
          mask_d = '0;
          cnt_d  = '0;
          acc_d  = '0;
        end
      end

      // string ended with an entity still open
      if (!done && !fail && last_i) begin
        fail = 1'b1;
      end

      if (fail) begin
        pack_o        = '0;
        pack_o.valid  = 1'b1;
        pack_o.status = fst;
        pack_o.last   = 1'b1;
        mode_d        = MODE_PLAIN;
        mask_d        = '0;
        cnt_d         = '0;
        acc_d         = '0;
        drop_d        = !last_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      mask_q <= '0;
      cnt_q  <= '0;
      acc_q  <= '0;
      drop_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      mask_q <= mask_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      drop_q <= drop_d;
    end
  end

endmodule

// ----- design/xed_out_queue.sv -----
// Result register: holds one item's results and sends them one per cycle unless stalled
module xed_out_queue import xed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  pack_t      pack_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       out_last_o
);

  pack_t      pack_q;
  logic [1:0] idx_q;
  logic       at_end;
  logic       take;

  assign at_end      = (idx_q == pack_q.top);
  assign take        = pack_q.valid && !out_stall_i;
  assign free_o      = !pack_q.valid || (take && at_end);
  assign out_valid_o = pack_q.valid;
  assign out_byte_o  = pack_q.bytes[idx_q];
  assign status_o    = pack_q.status;
  assign out_last_o  = pack_q.last && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q <= '0;
      idx_q  <= '0;
    end else if (load_i) begin
      pack_q <= pack_i;
      idx_q  <= '0;
    end else if (take) begin
      if (at_end) begin
        pack_q.valid <= 1'b0;
        idx_q        <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

// ----- design/xml_entity_to_utf8_decoder.sv -----
// XML entity decoder to UTF-8: input register, parser and result register
// Each item is held in the input register, then decoded and loaded into the
// result register; one item per cycle is taken while that register is free, and
// the n bytes of a numeric reference go out one per cycle while not stalled.
// Reset: rst_ni asynchronous, active low; returns to plain text, no items held.
`include "xml_entity_to_utf8_decoder_defines.svh"
module xml_entity_to_utf8_decoder import xed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       out_last_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       free;
  logic       step;
  logic       in_take;
  pack_t      pack;

  assign step       = in_valid_q && free;
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  xed_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .pack_o (pack)
  );

  xed_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .pack_i      (pack),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .out_last_o  (out_last_o)
  );

  `XED_ASSERT_NOW(a_stall_needs_busy, in_stall_o, out_valid_o, "input stalled with result register empty")
  `XED_ASSERT_NOW(a_err_is_last, out_valid_o && status_o != ST_OK, out_last_o && out_byte_o == 8'h00, "error item not final or nonzero")
  `XED_ASSERT_NOW(a_status_code, out_valid_o, status_o == ST_OK || status_o == ST_BAD_ESC || status_o == ST_BAD_CP, "undefined status code")
  `XED_ASSERT_NEXT(a_take_holds, in_take, in_valid_q, "accepted item not held")

endmodule
